FILE: rtl/rdi_pkg.sv
// ----------------------------------------------------------------------------
// rdi_pkg
// Shared types and constants of the ray/disc intersection block.
// ----------------------------------------------------------------------------
package rdi_pkg;

	localparam int CoordW = 32;
	localparam int AxisW  = 18;
	localparam int RadW   = 31;
	localparam int EpsW   = 17;
	localparam int DepthW = 31;
	// Quotient bits produced by the divider, one per stage.
	localparam int QuotW  = 31;
	localparam int AddrW  = 5;

	localparam logic [DepthW-1:0] DepthMax = {DepthW{1'b1}};

	typedef enum logic [2:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_NORMAL_X = 3'd3,
		REG_NORMAL_Y = 3'd4,
		REG_NORMAL_Z = 3'd5,
		REG_RADIUS   = 3'd6,
		REG_EPS      = 3'd7
	} reg_idx_t;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [AxisW-1:0]  axis_t;

endpackage

FILE: rtl/ray_disc_intersection.sv
// ----------------------------------------------------------------------------
// ray_disc_intersection
// Tests a stream of rays against one disc held in configuration registers.
// ----------------------------------------------------------------------------
// The block accepts one ray per clock cycle while the result side is not
// stalled, and returns one result for each ray, in order. The pipeline depth
// is set by the restoring divider that forms t: it yields one of
// the 31 quotient bits per pipeline stage, and the stages around it form the
// dot products, the hit point and the squared-radius test. A stall on the
// result side holds the whole pipeline. The user must write disc registers
// through the APB port only while no ray is in flight; it is not enforced.
module ray_disc_intersection (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [rdi_pkg::AddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Rays in
	input  logic        s_tvalid,
	output logic        s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
	input  logic [191:0] s_tdata,
	// Results out
	output logic        m_tvalid,
	input  logic        m_tready,
	// depth [30:0], zero [31]
	output logic [31:0] m_tdata,
	// hit [0]
	output logic        m_tuser
);

	localparam int QW  = rdi_pkg::QuotW;
	localparam int EW  = 52;  // axis . direction
	localparam int NW  = 53;  // (center - origin) . axis
	localparam int PW  = 49;  // hit point offset from center

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	rdi_pkg::coord_t c_q [3];
	rdi_pkg::axis_t  n_q [3];
	logic [rdi_pkg::RadW-1:0] radius_q;
	logic [rdi_pkg::EpsW-1:0] eps_q;
	rdi_pkg::reg_idx_t widx, ridx;

	assign pready = 1'b1;
	assign widx   = rdi_pkg::reg_idx_t'(paddr[4:2]);
	assign ridx   = rdi_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q[0]   <= '0;
			c_q[1]   <= '0;
			c_q[2]   <= '0;
			n_q[0]   <= '0;
			n_q[1]   <= '0;
			n_q[2]   <= 18'sd65536;
			radius_q <= 31'd65536;
			eps_q    <= 17'd1;
		end else if (psel && penable && pwrite && pready) begin
			case (widx)
				rdi_pkg::REG_CENTER_X: c_q[0]   <= pwdata;
				rdi_pkg::REG_CENTER_Y: c_q[1]   <= pwdata;
				rdi_pkg::REG_CENTER_Z: c_q[2]   <= pwdata;
				rdi_pkg::REG_NORMAL_X: n_q[0]   <= pwdata[rdi_pkg::AxisW-1:0];
				rdi_pkg::REG_NORMAL_Y: n_q[1]   <= pwdata[rdi_pkg::AxisW-1:0];
				rdi_pkg::REG_NORMAL_Z: n_q[2]   <= pwdata[rdi_pkg::AxisW-1:0];
				rdi_pkg::REG_RADIUS:   radius_q <= pwdata[rdi_pkg::RadW-1:0];
				rdi_pkg::REG_EPS:      eps_q    <= pwdata[rdi_pkg::EpsW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			rdi_pkg::REG_CENTER_X: prdata = c_q[0];
			rdi_pkg::REG_CENTER_Y: prdata = c_q[1];
			rdi_pkg::REG_CENTER_Z: prdata = c_q[2];
			rdi_pkg::REG_NORMAL_X: prdata = {{14{1'b0}}, n_q[0]};
			rdi_pkg::REG_NORMAL_Y: prdata = {{14{1'b0}}, n_q[1]};
			rdi_pkg::REG_NORMAL_Z: prdata = {{14{1'b0}}, n_q[2]};
			rdi_pkg::REG_RADIUS:   prdata = {1'b0, radius_q};
			rdi_pkg::REG_EPS:      prdata = {15'd0, eps_q};
			default:               prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline control: every stage moves when the output is free.
	// ------------------------------------------------------------------
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Stage 1: capture the ray and form center - origin.
	logic                 v_s1;
	rdi_pkg::coord_t      o_s1 [3];
	rdi_pkg::coord_t      d_s1 [3];
	logic signed [32:0]   df_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				o_s1[i]  <= s_tdata[32*i +: 32];
				d_s1[i]  <= s_tdata[96 + 32*i +: 32];
				df_s1[i] <= $signed({c_q[i][31], c_q[i]})
					- $signed({s_tdata[32*i + 31], s_tdata[32*i +: 32]});
			end
		end
	end

	// Stage 2: the six products.
	logic               v_s2;
	rdi_pkg::coord_t    o_s2 [3];
	rdi_pkg::coord_t    d_s2 [3];
	logic signed [49:0] pe_s2 [3];
	logic signed [50:0] pn_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				o_s2[i]  <= o_s1[i];
				d_s2[i]  <= d_s1[i];
				pe_s2[i] <= n_q[i] * d_s1[i];
				pn_s2[i] <= df_s1[i] * n_q[i];
			end
		end
	end

	// Stage 3: dot products.
	logic                 v_s3;
	rdi_pkg::coord_t      o_s3 [3];
	rdi_pkg::coord_t      d_s3 [3];
	logic signed [EW-1:0] e_s3;
	logic signed [NW-1:0] num_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			o_s3   <= o_s2;
			d_s3   <= d_s2;
			e_s3   <= EW'(pe_s2[0]) + EW'(pe_s2[1]) + EW'(pe_s2[2]);
			num_s3 <= NW'(pn_s2[0]) + NW'(pn_s2[1]) + NW'(pn_s2[2]);
		end
	end

	// Stage 4: magnitudes, parallel test and sign test.
	logic            v_s4;
	rdi_pkg::coord_t o_s4 [3];
	rdi_pkg::coord_t d_s4 [3];
	logic [EW-1:0]   ae_s4;
	logic [NW-1:0]   an_s4;
	logic            miss_s4;
	logic [EW-1:0]   ae_c;
	logic [NW-1:0]   an_c;
	logic            sign_bad;

	assign ae_c     = e_s3[EW-1] ? EW'(-e_s3) : EW'(e_s3);
	assign an_c     = num_s3[NW-1] ? NW'(-num_s3) : NW'(num_s3);
	assign sign_bad = (num_s3 != '0) && (num_s3[NW-1] != e_s3[EW-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			o_s4    <= o_s3;
			d_s4    <= d_s3;
			ae_s4   <= ae_c;
			an_s4   <= an_c;
			miss_s4 <= (ae_c == '0) || (ae_c < {19'd0, eps_q, 16'd0}) || sign_bad;
		end
	end

	// Stage 5: saturation test and divider seed. The top quotient bits are
	// known to be zero once t is below the saturation limit, so the partial
	// remainder starts from the numerator's high part.
	logic               dv_v    [QW+1];
	logic [EW-1:0]      dv_rem  [QW+1];
	logic [QW-1:0]      dv_q    [QW+1];
	logic [QW-1:0]      dv_n    [QW+1];
	logic [EW-1:0]      dv_ae   [QW+1];
	logic               dv_miss [QW+1];
	logic               dv_sat  [QW+1];
	rdi_pkg::coord_t    dv_o    [QW+1][3];
	rdi_pkg::coord_t    dv_d    [QW+1][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v[0] <= 1'b0;
		else if (adv) dv_v[0] <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_o[0]    <= o_s4;
			dv_d[0]    <= d_s4;
			dv_ae[0]   <= ae_s4;
			dv_miss[0] <= miss_s4;
			dv_sat[0]  <= {15'd0, an_s4} >= {1'b0, ae_s4, 15'd0};
			dv_rem[0]  <= EW'(an_s4[NW-1:15]);
			dv_q[0]    <= '0;
			dv_n[0]    <= {an_s4[14:0], 16'd0};
		end
	end

	// Stages 6 to 36: one restoring division step each.
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [EW:0] sh;
		logic        ge;
		assign sh = {dv_rem[k], dv_n[k][QW-1]};
		assign ge = sh >= {1'b0, dv_ae[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[k+1] <= 1'b0;
			else if (adv) dv_v[k+1] <= dv_v[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_o[k+1]    <= dv_o[k];
				dv_d[k+1]    <= dv_d[k];
				dv_ae[k+1]   <= dv_ae[k];
				dv_miss[k+1] <= dv_miss[k];
				dv_sat[k+1]  <= dv_sat[k];
				dv_n[k+1]    <= {dv_n[k][QW-2:0], 1'b0};
				dv_q[k+1]    <= {dv_q[k][QW-2:0], ge};
				dv_rem[k+1]  <= ge ? EW'(sh - {1'b0, dv_ae[k]}) : sh[EW-1:0];
			end
		end
	end

	// Stage 37: final t.
	logic                     v_s37, miss_s37;
	logic [rdi_pkg::DepthW-1:0] t_s37;
	rdi_pkg::coord_t          o_s37 [3];
	rdi_pkg::coord_t          d_s37 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s37 <= 1'b0;
		else if (adv) v_s37 <= dv_v[QW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			o_s37    <= dv_o[QW];
			d_s37    <= dv_d[QW];
			miss_s37 <= dv_miss[QW];
			t_s37    <= dv_sat[QW] ? rdi_pkg::DepthMax : dv_q[QW];
		end
	end

	// Stage 38: t * dir.
	logic                     v_s38, miss_s38;
	logic [rdi_pkg::DepthW-1:0] t_s38;
	rdi_pkg::coord_t          o_s38 [3];
	logic signed [63:0]       td_s38 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s38 <= 1'b0;
		else if (adv) v_s38 <= v_s37;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			o_s38    <= o_s37;
			miss_s38 <= miss_s37;
			t_s38    <= t_s37;
			for (int i = 0; i < 3; i++)
				td_s38[i] <= $signed({1'b0, t_s37}) * d_s37[i];
		end
	end

	// Stage 39: hit point relative to the center (arithmetic shift is floor).
	logic                     v_s39, miss_s39;
	logic [rdi_pkg::DepthW-1:0] t_s39;
	logic signed [PW-1:0]     p_s39 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s39 <= 1'b0;
		else if (adv) v_s39 <= v_s38;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_s39 <= miss_s38;
			t_s39    <= t_s38;
			for (int i = 0; i < 3; i++)
				p_s39[i] <= PW'(o_s38[i]) + PW'(td_s38[i] >>> 16) - PW'(c_q[i]);
		end
	end

	// Stage 40: magnitudes and the per-axis radius test.
	logic                     v_s40, miss_s40;
	logic [rdi_pkg::DepthW-1:0] t_s40;
	logic [rdi_pkg::RadW-1:0] ap_s40 [3];
	logic [PW-1:0]            ap_c [3];
	logic [2:0]               far_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ap_c[i]  = p_s39[i][PW-1] ? PW'(-p_s39[i]) : PW'(p_s39[i]);
			far_c[i] = ap_c[i] > {18'd0, radius_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s40 <= 1'b0;
		else if (adv) v_s40 <= v_s39;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_s40 <= miss_s39 || (far_c != 3'd0);
			t_s40    <= t_s39;
			for (int i = 0; i < 3; i++)
				ap_s40[i] <= ap_c[i][rdi_pkg::RadW-1:0];
		end
	end

	// Stage 41: squares.
	logic                     v_s41, miss_s41;
	logic [rdi_pkg::DepthW-1:0] t_s41;
	logic [61:0]              sq_s41 [3];
	logic [61:0]              rr_s41;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s41 <= 1'b0;
		else if (adv) v_s41 <= v_s40;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_s41 <= miss_s40;
			t_s41    <= t_s40;
			rr_s41   <= radius_q * radius_q;
			for (int i = 0; i < 3; i++)
				sq_s41[i] <= ap_s40[i] * ap_s40[i];
		end
	end

	// Stage 42: squared-length test and the output register.
	logic                     v_s42, hit_s42;
	logic [rdi_pkg::DepthW-1:0] depth_s42;
	logic [63:0]              sum_c;
	logic                     hit_c;

	assign sum_c = 64'(sq_s41[0]) + 64'(sq_s41[1]) + 64'(sq_s41[2]);
	assign hit_c = !miss_s41 && (sum_c <= {2'd0, rr_s41});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s42 <= 1'b0;
		else if (adv) v_s42 <= v_s41;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s42   <= hit_c;
			depth_s42 <= hit_c ? t_s41 : '0;
		end
	end

	assign m_tvalid = v_s42;
	assign m_tdata  = {1'b0, depth_s42};
	assign m_tuser  = hit_s42;

endmodule

FILE: rtl/rdi_checker.sv
// ----------------------------------------------------------------------------
// rdi_checker
// Port-level checks of the ray/disc intersection block.
// ----------------------------------------------------------------------------
module rdi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// A missed ray always reports zero depth.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == 32'd0))
		else $error("miss with nonzero depth");

	// The pad bit above depth is always clear.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[31])
		else $error("depth pad bit set");

	// A stalled result holds until its transfer.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

	// The input side is never blocked while the output is free.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> (s_tready && pready))
		else $error("input blocked with free output");

endmodule

bind ray_disc_intersection rdi_checker u_rdi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pready   (pready),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ray/disc intersection testbench
// Sends directed and random rays through the stream port, changes the disc
// through the APB port between phases, and checks every result against a
// local predictor of the intersection math. In some phases either side idles at random.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		logic             hit;
		logic [rdi_pkg::DepthW-1:0] depth;
	} hit_result_t;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [rdi_pkg::AddrW-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               s_tvalid, s_tready;
	logic [191:0]       s_tdata;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [31:0]        m_tdata;
	logic               m_tuser;

	logic signed [31:0] disc_center [3];
	logic signed [17:0] disc_axis [3];
	logic [30:0]        disc_radius;
	logic [16:0]        disc_eps;

	hit_result_t        pending_hits [$];
	int                 mismatches;
	int                 send_idle_pct;
	int                 recv_stall_pct;
	longint             cycle_count = 0;

	ray_disc_intersection u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The stall decision is redrawn every cycle from the current percentage.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
		cycle_count <= cycle_count + 1;
		if (cycle_count > 64'd2000000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		hit_result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result hit=%0d depth=%h", m_tuser, m_tdata[30:0]);
			end else begin
				want = pending_hits.pop_front();
				if (want.hit !== m_tuser || want.depth !== m_tdata[30:0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp hit=%0d depth=%h, got hit=%0d depth=%h",
							want.hit, want.depth, m_tuser, m_tdata[30:0]);
				end
			end
		end
	end

	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic hit_result_t intersect_disc(input logic [191:0] ray);
		hit_result_t        res;
		logic signed [63:0] org [3];
		logic signed [63:0] dir [3];
		logic signed [63:0] dot_e, dot_num, prod, pnt;
		logic [63:0]        mag_e, mag_num, quot, t, apnt;
		logic [127:0]       sq_sum, frac_q;
		res = '0;
		dot_e = 0;
		dot_num = 0;
		for (int i = 0; i < 3; i++) begin
			org[i] = $signed(ray[32*i +: 32]);
			dir[i] = $signed(ray[96 + 32*i +: 32]);
			dot_e += 64'(disc_axis[i]) * dir[i];
			dot_num += (64'(disc_center[i]) - org[i]) * 64'(disc_axis[i]);
		end
		mag_e = abs64(dot_e);
		if (mag_e == 0 || mag_e < {31'd0, disc_eps, 16'd0})
			return res;
		if (dot_num != 0 && ((dot_num < 0) != (dot_e < 0)))
			return res;
		mag_num = abs64(dot_num);
		quot = mag_num / mag_e;
		if (quot >= 64'd32768) begin
			t = 64'h7FFFFFFF;
		end else begin
			frac_q = ({64'd0, mag_num % mag_e} << 16) / {64'd0, mag_e};
			t = (quot << 16) | frac_q[15:0];
		end
		sq_sum = 0;
		for (int i = 0; i < 3; i++) begin
			prod = $signed(t) * dir[i];
			pnt = org[i] + (prod >>> 16) - 64'(disc_center[i]);
			apnt = abs64(pnt);
			if (apnt > disc_radius)
				return res;
			sq_sum += apnt * apnt;
		end
		if (sq_sum > 128'(disc_radius) * 128'(disc_radius))
			return res;
		res.hit = 1'b1;
		res.depth = t[30:0];
		return res;
	endfunction

	task automatic write_reg(input rdi_pkg::reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= rdi_pkg::AddrW'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			rdi_pkg::REG_CENTER_X, rdi_pkg::REG_CENTER_Y, rdi_pkg::REG_CENTER_Z:
				disc_center[idx] = value;
			rdi_pkg::REG_NORMAL_X, rdi_pkg::REG_NORMAL_Y, rdi_pkg::REG_NORMAL_Z:
				disc_axis[idx - rdi_pkg::REG_NORMAL_X] = value[17:0];
			rdi_pkg::REG_RADIUS:
				disc_radius = value[30:0];
			default:
				disc_eps = value[16:0];
		endcase
	endtask

	task automatic set_disc(input logic [31:0] cx, cy, cz, nx, ny, nz, rad, eps);
		write_reg(rdi_pkg::REG_CENTER_X, cx);
		write_reg(rdi_pkg::REG_CENTER_Y, cy);
		write_reg(rdi_pkg::REG_CENTER_Z, cz);
		write_reg(rdi_pkg::REG_NORMAL_X, nx);
		write_reg(rdi_pkg::REG_NORMAL_Y, ny);
		write_reg(rdi_pkg::REG_NORMAL_Z, nz);
		write_reg(rdi_pkg::REG_RADIUS, rad);
		write_reg(rdi_pkg::REG_EPS, eps);
	endtask

	// Valid stays high from one transfer into the next unless the sender idles.
	task automatic send_ray(input logic [191:0] ray);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ray;
		pending_hits.push_back(intersect_disc(ray));
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_coord(input int scale);
		case ($urandom_range(4))
			0: return $urandom;
			1: return {$urandom_range(1) ? 1'b1 : 1'b0, 31'h7FFFFFFF} ^ $urandom_range(1);
			default: return 32'($signed($urandom_range(2*scale) - scale));
		endcase
	endfunction

	// Aims a ray at a random point near the disc center so that hits occur.
	function automatic logic [191:0] aimed_ray(input int spread);
		logic [31:0] org [3];
		logic [31:0] dir [3];
		for (int i = 0; i < 3; i++) begin
			dir[i] = 32'($signed($urandom_range(2*spread) - spread));
			org[i] = disc_center[i] - 32'($signed(disc_axis[i]) * 3)
				+ 32'($signed($urandom_range(131072)) - 65536);
		end
		dir[$urandom_range(2)] = 32'($signed(disc_axis[2] != 0 ? disc_axis[2] : 18'sd65536));
		return {dir[2], dir[1], dir[0], org[2], org[1], org[0]};
	endfunction

	function automatic logic [191:0] random_ray();
		logic [191:0] ray;
		if ($urandom_range(3) == 0) begin
			for (int i = 0; i < 6; i++)
				ray[32*i +: 32] = pick_coord(1 << 18);
			return ray;
		end
		return aimed_ray(1 << ($urandom_range(17)));
	endfunction

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// Straight down the axis onto the unit disc at the origin.
		send_ray({32'sh00010000, 32'sh0, 32'sh0, 32'shFFFE0000, 32'sh0, 32'sh0});
		// Zero numerator: origin on the disc plane.
		send_ray({32'sh00010000, 32'sh0, 32'sh0, 32'sh0, 32'sh00008000, 32'sh0});
		// Parallel ray and ray going away.
		send_ray({32'sh0, 32'sh00010000, 32'sh0, 32'sh00010000, 32'sh0, 32'sh0});
		send_ray({32'sh00010000, 32'sh0, 32'sh0, 32'sh00020000, 32'sh0, 32'sh0});
		// Far hit point and a tiny direction that saturates t.
		send_ray({32'sh00010000, 32'sh0, 32'sh00010000, 32'shFFFF0000, 32'sh0, 32'sh00030000});
		send_ray({32'sh00000002, 32'sh0, 32'sh0, 32'sh80000000, 32'sh0, 32'sh0});
		send_ray({32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF});
		send_ray({32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000});
		send_ray('1);
		send_ray('0);
		drain_results();
		// Zero eps with a zero denominator, and a non-unit axis.
		set_disc(32'h7FFFFFFF, 32'h80000000, 32'h00012345, 32'h1FFFF, 32'h20000, 32'h10000,
			32'h7FFFFFFF, 0);
		send_ray('0);
		send_ray({32'sh00010000, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0});
		for (int i = 0; i < 8; i++)
			send_ray(aimed_ray(1 << 16));
		drain_results();
		// Zero radius and a large eps of 0x10000.
		set_disc(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000);
		send_ray({32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'shFFFF0000});
		send_ray({32'sh0, 32'sh0, 32'sh00010000, 32'sh0, 32'sh0, 32'shFFFF0000});
		send_ray({32'sh0, 32'sh0, 32'sh00008000, 32'sh0, 32'sh0, 32'shFFFF0000});
		drain_results();
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct, input int count);
		logic [31:0] ax [3];
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < 3; i++)
			ax[i] = 32'($signed($urandom_range(131072)) - 65536);
		set_disc(pick_coord(1 << 20), pick_coord(1 << 20), pick_coord(1 << 20),
			ax[0], ax[1], ax[2], $urandom_range(1) ? $urandom : $urandom_range(1 << 20),
			$urandom_range(3) == 0 ? $urandom_range(65536) : $urandom_range(4));
		for (int i = 0; i < count; i++)
			send_ray(random_ray());
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		disc_center = '{0, 0, 0};
		disc_axis = '{0, 0, 18'sd65536};
		disc_radius = 31'd65536;
		disc_eps = 17'd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: test_random(0, 0, 150);
				1: test_random(56, 0, 150);
				2: test_random(0, 56, 150);
				default: test_random(31, 31, 150);
			endcase
		end
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
